// ===== src/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes and result status codes shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  // Operation codes carried on the cmd field.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Status codes carried on the status field.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

endpackage

`default_nettype wire

// ===== src/complex_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply and divide of complex signed fixed-point operands,
// with saturation and status; division by Smith's scaled method.
// ----------------------------------------------------------------------------
// The unit accepts one item in every cycle while the input is not stalled
// and returns one result per item, in order. All items pass through the
// two divider cell chains: FRAC_BITS + 1 cells form the Smith ratio and
// DATA_WIDTH cells form the two quotients, one bit per cell. Empty stages
// fill while the output is stalled, so the input is stalled only once every
// stage holds an item. FRAC_BITS must stay below DATA_WIDTH.
`default_nettype none

module complex_arithmetic_unit_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   cmd_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] y_re_o,
  output logic signed [DATA_WIDTH-1:0] y_im_o,
  output logic [1:0]                   status_o
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = (F + 1 > W + 1) ? F + 1 : W + 1;

  localparam logic signed [2*W:0] SAT_MAX = {{(W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W:0] SAT_MIN = {{(W+2){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [2*W:0] RND2    = (2*W+1)'((64'd1 << F) - 64'd1);
  localparam logic signed [2*W:0] ZERO2   = '0;
  localparam logic signed [W+F+1:0] RND3  = (W+F+2)'((64'd1 << F) - 64'd1);
  localparam logic signed [W+F+1:0] ZERO3 = '0;
  localparam logic [W-1:0] MAG_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MAG_MIN = {1'b1, {(W-1){1'b0}}};

  // Sideband records that travel with an item.
  typedef struct packed {
    logic [1:0]          cmd;
    logic                dz;
    logic                br_ge;
    logic                negr;
    logic signed [W-1:0] ar;
    logic signed [W-1:0] ai;
    logic signed [W-1:0] p;
    logic signed [W-1:0] s;
    logic [W-1:0]        eyr;
    logic [W-1:0]        eyi;
    logic                eovf;
  } sb1_t;

  typedef struct packed {
    logic [1:0]   cmd;
    logic         dz;
    logic [W-1:0] eyr;
    logic [W-1:0] eyi;
    logic         eovf;
  } sb2_t;

  typedef struct packed {
    logic [1:0]   cmd;
    logic         dz;
    logic         negq_re;
    logic         negq_im;
    logic         ovf0_re;
    logic         ovf0_im;
    logic [W-1:0] eyr;
    logic [W-1:0] eyi;
    logic         eovf;
  } sb3_t;

  // Saturate a wide signed value to W bits; returns {overflow, value}.
  function automatic logic [W:0] sat_fn(input logic signed [2*W:0] x);
    logic [W:0] res;
    if (x > SAT_MAX) begin
      res = {1'b1, SAT_MAX[W-1:0]};
    end else if (x < SAT_MIN) begin
      res = {1'b1, SAT_MIN[W-1:0]};
    end else begin
      res = {1'b0, x[W-1:0]};
    end
    return res;
  endfunction

  // Shift a ratio product right by F bits, rounding toward zero.
  function automatic logic signed [W+1:0] trf(input logic signed [W+F+1:0] x);
    logic signed [W+F+1:0] xr;
    xr = x + (x[W+F+1] ? RND3 : ZERO3);
    xr = xr >>> F;
    return xr[W+1:0];
  endfunction

  // Apply the sign to a quotient magnitude and saturate; returns {ovf, value}.
  function automatic logic [W:0] qsat(input logic [W-1:0] q, input logic neg,
                                      input logic ovf0);
    logic       big;
    logic [W:0] res;
    big = neg ? (q > MAG_MIN) : (q > MAG_MAX);
    if (ovf0 || big) begin
      res = {1'b1, (neg ? MAG_MIN : MAG_MAX)};
    end else begin
      res = {1'b0, (neg ? (~q + W'(1)) : q)};
    end
    return res;
  endfunction

  logic rdy0, rdy1, rdy3, rdy4, rdy5, rdy6;
  logic c1_in_ready, c1_out_valid, c2_in_ready, c2_out_valid;

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  logic                v0_q;
  logic [1:0]          cmd0_q;
  logic signed [W-1:0] ar0_q, ai0_q, br0_q, bi0_q;

  assign rdy0       = ~v0_q | rdy1;
  assign in_stall_o = ~rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      cmd0_q <= cmd_i;
      ar0_q  <= a_re_i;
      ai0_q  <= a_im_i;
      br0_q  <= b_re_i;
      bi0_q  <= b_im_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: operand magnitudes, Smith branch, sums and partial products.
  logic [W-1:0]        abr, abi, ap, as1;
  logic                br_ge;
  logic signed [W-1:0] p1, s1;
  logic signed [W:0]   sre, sim;

  assign abr   = br0_q[W-1] ? W'(-br0_q) : W'(br0_q);
  assign abi   = bi0_q[W-1] ? W'(-bi0_q) : W'(bi0_q);
  assign br_ge = (abr >= abi);
  assign p1    = br_ge ? br0_q : bi0_q;
  assign s1    = br_ge ? bi0_q : br0_q;
  assign ap    = br_ge ? abr : abi;
  assign as1   = br_ge ? abi : abr;
  assign sre   = (cmd0_q == cau_pkg::CMD_SUB) ? ((W+1)'(ar0_q) - (W+1)'(br0_q))
                                               : ((W+1)'(ar0_q) + (W+1)'(br0_q));
  assign sim   = (cmd0_q == cau_pkg::CMD_SUB) ? ((W+1)'(ai0_q) - (W+1)'(bi0_q))
                                               : ((W+1)'(ai0_q) + (W+1)'(bi0_q));

  logic                  v1_q;
  logic [1:0]            cmd1_q;
  logic                  dz1_q, brge1_q, negr1_q;
  logic [W-1:0]          rem1_q, dv1_q;
  logic [F:0]            num1_q;
  logic signed [W-1:0]   ar1_q, ai1_q, p1_q, s1_q;
  logic signed [W:0]     sre1_q, sim1_q;
  logic signed [2*W-1:0] prr1_q, pii1_q, pir1_q, pri1_q;

  assign rdy1 = ~v1_q | c1_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      cmd1_q  <= cmd0_q;
      dz1_q   <= (br0_q == '0) && (bi0_q == '0);
      brge1_q <= br_ge;
      negr1_q <= p1[W-1] ^ s1[W-1];
      rem1_q  <= {1'b0, as1[W-1:1]};
      num1_q  <= {as1[0], {F{1'b0}}};
      dv1_q   <= ap;
      ar1_q   <= ar0_q;
      ai1_q   <= ai0_q;
      p1_q    <= p1;
      s1_q    <= s1;
      sre1_q  <= sre;
      sim1_q  <= sim;
      prr1_q  <= ar0_q * br0_q;
      pii1_q  <= ai0_q * bi0_q;
      pir1_q  <= ai0_q * br0_q;
      pri1_q  <= ar0_q * bi0_q;
    end
  end

  // --------------------------------------------------------------------------
  // Early results for add, subtract and multiply, and the ratio divider.
  logic signed [2*W:0] mre, mim, mre_r, mim_r, tre, tim, xre, xim;
  logic [W:0]          sat_re, sat_im;
  sb1_t                sb1_in, sb1_out;
  logic [0:0][W-1:0]   c1_rem, c1_d;
  logic [0:0][F:0]     c1_num_in, c1_num_out;
  logic [$bits(sb1_t)-1:0] c1_sb_out;

  assign mre    = (2*W+1)'(prr1_q) - (2*W+1)'(pii1_q);
  assign mim    = (2*W+1)'(pir1_q) + (2*W+1)'(pri1_q);
  assign mre_r  = mre + (mre[2*W] ? RND2 : ZERO2);
  assign mim_r  = mim + (mim[2*W] ? RND2 : ZERO2);
  assign tre    = mre_r >>> F;
  assign tim    = mim_r >>> F;
  assign xre    = (cmd1_q == cau_pkg::CMD_MUL) ? tre : (2*W+1)'(sre1_q);
  assign xim    = (cmd1_q == cau_pkg::CMD_MUL) ? tim : (2*W+1)'(sim1_q);
  assign sat_re = sat_fn(xre);
  assign sat_im = sat_fn(xim);

  assign sb1_in.cmd   = cmd1_q;
  assign sb1_in.dz    = dz1_q;
  assign sb1_in.br_ge = brge1_q;
  assign sb1_in.negr  = negr1_q;
  assign sb1_in.ar    = ar1_q;
  assign sb1_in.ai    = ai1_q;
  assign sb1_in.p     = p1_q;
  assign sb1_in.s     = s1_q;
  assign sb1_in.eyr   = sat_re[W-1:0];
  assign sb1_in.eyi   = sat_im[W-1:0];
  assign sb1_in.eovf  = sat_re[W] | sat_im[W];

  assign c1_rem[0]    = rem1_q;
  assign c1_d[0]      = dv1_q;
  assign c1_num_in[0] = num1_q;

  cau_div_chain #(
    .DW    (W),
    .QW    (F + 1),
    .LANES (1),
    .SBW   ($bits(sb1_t))
  ) u_ratio_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (c1_in_ready),
    .rem_i       (c1_rem),
    .num_i       (c1_num_in),
    .d_i         (c1_d),
    .sb_i        (sb1_in),
    .out_valid_o (c1_out_valid),
    .out_ready_i (rdy3),
    .num_o       (c1_num_out),
    .sb_o        (c1_sb_out)
  );

  assign sb1_out = c1_sb_out;

  // --------------------------------------------------------------------------
  // Stage 3: signed ratio times the smaller divisor part and the numerator.
  logic signed [F+1:0]   r3;
  logic                  v3_q;
  logic signed [W+F+1:0] ms3_q, mar3_q, mai3_q;
  sb1_t                  sb3_q;

  assign r3   = sb1_out.negr ? -$signed({1'b0, c1_num_out[0]})
                             : $signed({1'b0, c1_num_out[0]});
  assign rdy3 = ~v3_q | rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= c1_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      ms3_q  <= r3 * sb1_out.s;
      mar3_q <= r3 * sb1_out.ar;
      mai3_q <= r3 * sb1_out.ai;
      sb3_q  <= sb1_out;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: scaled denominator and numerators.
  logic signed [W+1:0] ts, tar, tai, pe, are, aie, den, nr, ni;
  logic                v4_q;
  logic signed [W+1:0] den4_q, nr4_q, ni4_q;
  sb2_t                sb4_q;

  assign ts  = trf(ms3_q);
  assign tar = trf(mar3_q);
  assign tai = trf(mai3_q);
  assign pe  = (W+2)'(sb3_q.p);
  assign are = (W+2)'(sb3_q.ar);
  assign aie = (W+2)'(sb3_q.ai);
  assign den = pe + ts;
  assign nr  = sb3_q.br_ge ? (are + tai) : (tar + aie);
  assign ni  = sb3_q.br_ge ? (aie - tar) : (tai - are);

  assign rdy4 = ~v4_q | rdy5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      den4_q    <= den;
      nr4_q     <= nr;
      ni4_q     <= ni;
      sb4_q.cmd <= sb3_q.cmd;
      sb4_q.dz  <= sb3_q.dz;
      sb4_q.eyr <= sb3_q.eyr;
      sb4_q.eyi <= sb3_q.eyi;
      sb4_q.eovf <= sb3_q.eovf;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: magnitudes and the quotient overflow pre-check.
  logic [W:0]   aden, anr, ani;
  logic [W+F:0] nn_re, nn_im;
  logic [F:0]   top_re, top_im;
  logic         ovf0_re, ovf0_im;

  assign aden    = den4_q[W+1] ? (W+1)'(-den4_q) : (W+1)'(den4_q);
  assign anr     = nr4_q[W+1]  ? (W+1)'(-nr4_q)  : (W+1)'(nr4_q);
  assign ani     = ni4_q[W+1]  ? (W+1)'(-ni4_q)  : (W+1)'(ni4_q);
  assign nn_re   = {anr, {F{1'b0}}};
  assign nn_im   = {ani, {F{1'b0}}};
  assign top_re  = nn_re[W+F:W];
  assign top_im  = nn_im[W+F:W];
  assign ovf0_re = (CW'(top_re) >= CW'(aden));
  assign ovf0_im = (CW'(top_im) >= CW'(aden));

  logic              v5_q;
  logic [1:0][W:0]   rem5_q;
  logic [1:0][W-1:0] num5_q;
  logic [1:0][W:0]   d5;
  logic [W:0]        dv5_q;
  sb3_t              sb5_q;

  assign rdy5  = ~v5_q | c2_in_ready;
  assign d5[0] = dv5_q;
  assign d5[1] = dv5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      rem5_q[0]     <= ovf0_re ? '0 : (W+1)'(top_re);
      rem5_q[1]     <= ovf0_im ? '0 : (W+1)'(top_im);
      num5_q[0]     <= nn_re[W-1:0];
      num5_q[1]     <= nn_im[W-1:0];
      dv5_q         <= aden;
      sb5_q.cmd     <= sb4_q.cmd;
      sb5_q.dz      <= sb4_q.dz;
      sb5_q.negq_re <= nr4_q[W+1] ^ den4_q[W+1];
      sb5_q.negq_im <= ni4_q[W+1] ^ den4_q[W+1];
      sb5_q.ovf0_re <= ovf0_re;
      sb5_q.ovf0_im <= ovf0_im;
      sb5_q.eyr     <= sb4_q.eyr;
      sb5_q.eyi     <= sb4_q.eyi;
      sb5_q.eovf    <= sb4_q.eovf;
    end
  end

  // --------------------------------------------------------------------------
  // Quotient divider, real and imaginary lanes side by side.
  logic [1:0][W-1:0]       c2_num_out;
  logic [$bits(sb3_t)-1:0] c2_sb_out;
  sb3_t                    sb6;

  cau_div_chain #(
    .DW    (W + 1),
    .QW    (W),
    .LANES (2),
    .SBW   ($bits(sb3_t))
  ) u_quot_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_ready_o  (c2_in_ready),
    .rem_i       (rem5_q),
    .num_i       (num5_q),
    .d_i         (d5),
    .sb_i        (sb5_q),
    .out_valid_o (c2_out_valid),
    .out_ready_i (rdy6),
    .num_o       (c2_num_out),
    .sb_o        (c2_sb_out)
  );

  assign sb6 = c2_sb_out;

  // --------------------------------------------------------------------------
  // Output stage: result select and output register.
  logic [W:0]   q_re, q_im;
  logic [W-1:0] yre_d, yim_d;
  logic [1:0]   st_d;
  logic         ov_q;
  logic [W-1:0] yre_q, yim_q;
  logic [1:0]   st_q;

  assign q_re = qsat(c2_num_out[0], sb6.negq_re, sb6.ovf0_re);
  assign q_im = qsat(c2_num_out[1], sb6.negq_im, sb6.ovf0_im);

  always_comb begin
    unique case (sb6.cmd)
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_MUL: begin
        yre_d = sb6.eyr;
        yim_d = sb6.eyi;
        st_d  = sb6.eovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
      end
      cau_pkg::CMD_DIV: begin
        if (sb6.dz) begin
          yre_d = '0;
          yim_d = '0;
          st_d  = cau_pkg::ST_DZ;
        end else begin
          yre_d = q_re[W-1:0];
          yim_d = q_im[W-1:0];
          st_d  = (q_re[W] | q_im[W]) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
        end
      end
    endcase
  end

  assign rdy6 = ~ov_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rdy6) begin
      ov_q <= c2_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy6) begin
      yre_q <= yre_d;
      yim_q <= yim_d;
      st_q  <= st_d;
    end
  end

  assign out_valid_o = ov_q;
  assign y_re_o      = yre_q;
  assign y_im_o      = yim_q;
  assign status_o    = st_q;

  // --------------------------------------------------------------------------
  // Assertions.
`ifndef ASSERT_OFF
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == cau_pkg::ST_DZ) |-> (y_re_o == '0 && y_im_o == '0))
    else $error("divide-by-zero result is not zero");

  a_transfer_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v0_q)
    else $error("input transfer did not reach the input stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v0_q && v1_q && v3_q && v4_q && v5_q && ov_q && out_stall_i))
    else $error("input stalled while a stage is free");
`endif

endmodule

`default_nettype wire

// ===== src/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// Restoring divider cell
// Takes one quotient bit: shifts the next dividend bit into the partial
// remainder, subtracts the divisor when it fits and shifts the bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_cell #(
  parameter int DW = 33,
  parameter int QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] d_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] num_o,
  output logic [DW-1:0] d_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_d, rem_q;
  logic [QW-1:0] num_d, num_q;
  logic [DW-1:0] d_q;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem_i, num_i[QW-1]};
  assign diff  = trial - {1'b0, d_i};
  assign fits  = (trial >= {1'b0, d_i});
  assign rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
  assign num_d = {num_i[QW-2:0], fits};

  // Cell registers advance with the stage enable.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      d_q   <= d_i;
    end
  end

  assign rem_o = rem_q;
  assign num_o = num_q;
  assign d_o   = d_q;

endmodule

`default_nettype wire

// ===== src/cau_div_chain.sv =====
// ----------------------------------------------------------------------------
// Divider cell chain
// A row of divider cells, one quotient bit per cell, with per-stage valid
// bits, a ready chain that fills bubbles, and a sideband shift line.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_chain #(
  parameter int DW    = 33,
  parameter int QW    = 32,
  parameter int LANES = 2,
  parameter int SBW   = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [LANES-1:0][DW-1:0]   rem_i,
  input  logic [LANES-1:0][QW-1:0]   num_i,
  input  logic [LANES-1:0][DW-1:0]   d_i,
  input  logic [SBW-1:0]             sb_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [LANES-1:0][QW-1:0]   num_o,
  output logic [SBW-1:0]             sb_o
);

  logic [QW-1:0]                      v_d, v_q;
  logic [QW-1:0]                      rdy;
  logic [QW-1:0][SBW-1:0]             sb_q;
  logic [LANES-1:0][QW-1:0][DW-1:0]   rem_w;
  logic [LANES-1:0][QW-1:0][QW-1:0]   num_w;
  logic [LANES-1:0][QW-1:0][DW-1:0]   d_w;

  // A stage takes new data when it is empty or its successor moves on.
  genvar j, l;
  generate
    for (j = 0; j < QW; j++) begin : g_rdy
      if (j == QW - 1) begin : g_last
        assign rdy[j] = ~v_q[j] | out_ready_i;
      end else begin : g_mid
        assign rdy[j] = ~v_q[j] | rdy[j+1];
      end
    end
  endgenerate

  // Valid bits shift along with the data.
  assign v_d = (rdy & {v_q[QW-2:0], in_valid_i}) | (~rdy & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Sideband travels next to the cells.
  generate
    for (j = 0; j < QW; j++) begin : g_sb
      if (j == 0) begin : g_first
        always_ff @(posedge clk_i) begin
          if (rdy[j]) begin
            sb_q[j] <= sb_i;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk_i) begin
          if (rdy[j]) begin
            sb_q[j] <= sb_q[j-1];
          end
        end
      end
    end
  endgenerate

  // Divider cells, one row per lane.
  generate
    for (l = 0; l < LANES; l++) begin : g_lane
      for (j = 0; j < QW; j++) begin : g_cell
        if (j == 0) begin : g_first
          cau_div_cell #(
            .DW(DW),
            .QW(QW)
          ) u_cell (
            .clk_i (clk_i),
            .en_i  (rdy[j]),
            .rem_i (rem_i[l]),
            .num_i (num_i[l]),
            .d_i   (d_i[l]),
            .rem_o (rem_w[l][j]),
            .num_o (num_w[l][j]),
            .d_o   (d_w[l][j])
          );
        end else begin : g_next
          cau_div_cell #(
            .DW(DW),
            .QW(QW)
          ) u_cell (
            .clk_i (clk_i),
            .en_i  (rdy[j]),
            .rem_i (rem_w[l][j-1]),
            .num_i (num_w[l][j-1]),
            .d_i   (d_w[l][j-1]),
            .rem_o (rem_w[l][j]),
            .num_o (num_w[l][j]),
            .d_o   (d_w[l][j])
          );
        end
      end
      assign num_o[l] = num_w[l][QW-1];
    end
  endgenerate

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[QW-1];
  assign sb_o        = sb_q[QW-1];

endmodule

`default_nettype wire
